FILE: rtl/tlbw_pkg.sv
// Shared types, codes and sizes for the two-level page walk TLB block.
package tlbw_pkg;

  // Action codes on the request channel
  localparam logic [1:0] ACT_XLATE = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_PHYS  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  // Walk phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DIR   = 2'd1;
  localparam logic [1:0] PH_TABLE = 2'd2;

  // Configuration register indexes (paddr[2])
  localparam logic REG_XLATE_ON = 1'b0;
  localparam logic REG_DIR_BASE = 1'b1;

  localparam int unsigned TLB_ENTRIES_DEF = 64;
  localparam int unsigned FRAME_W         = 20;
  localparam int unsigned OFFSET_W        = 12;

  // Front queue geometry
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // Priority encode group size for the hit / victim search
  localparam int unsigned GRP_SIZE  = 8;
  localparam int unsigned GRP_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_XLATE,
    OP_REPLY,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] word;
  } q_item_t;

  typedef struct packed {
    logic                xlate_on;
    logic [FRAME_W-1:0]  dir_base;
  } cfg_t;

  typedef struct packed {
    logic       lookup;
    logic [1:0] phase;
  } status_t;

endpackage

FILE: rtl/tlbw_if.sv
// Request and result channel interfaces.
interface tlbw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] linear_addr;
  logic [31:0] read_data;

  modport source (output valid, action, linear_addr, read_data, input ready);
  modport sink   (input valid, action, linear_addr, read_data, output ready);
endinterface

interface tlbw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;

  modport source (output valid, kind, address, input ready);
  modport sink   (input valid, kind, address, output ready);
endinterface

FILE: rtl/tlb_two_level_page_walk_top.sv
// Top level: two-level page walk MMU with TLB, configuration registers and checks.
// Pass-through translates and table replies go through queue and result register (a
//   flush acts on pop); a paged translate adds states CMP, GRP, SEL and RESP (tag
//   compare, two-level priority encode). One request per cycle while the queue has
//   room and results are taken; no pop during a lookup. Reset (synchronous, rst_n
//   low) clears valid bits, queue, walk phase, config registers; not tags or frames.
module tlb_two_level_page_walk_top #(
  parameter int unsigned TLB_ENTRIES = tlbw_pkg::TLB_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tlbw_in_if.sink      in_chan,
  tlbw_out_if.source   out_chan,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Configuration registers
  logic                           xlate_on_r, xlate_on_nxt;
  logic [tlbw_pkg::FRAME_W-1:0]   dir_base_r, dir_base_nxt;
  logic                           cfg_wr;
  tlbw_pkg::cfg_t                 cfg;

  // Front to back queue handoff
  logic                           pop;
  logic                           q_nonempty;
  tlbw_pkg::q_item_t              q_head;
  tlbw_pkg::status_t              sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    xlate_on_nxt = xlate_on_r;
    dir_base_nxt = dir_base_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        tlbw_pkg::REG_XLATE_ON: xlate_on_nxt = pwdata[0];
        tlbw_pkg::REG_DIR_BASE: dir_base_nxt = pwdata[tlbw_pkg::FRAME_W-1:0];
        default: xlate_on_nxt = xlate_on_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tlbw_pkg::REG_XLATE_ON: prdata = {31'd0, xlate_on_r};
      tlbw_pkg::REG_DIR_BASE: prdata = {12'd0, dir_base_r};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlate_on_r <= 1'b0;
      dir_base_r <= '0;
    end else begin
      xlate_on_r <= xlate_on_nxt;
      dir_base_r <= dir_base_nxt;
    end
  end

  assign cfg.xlate_on = xlate_on_r;
  assign cfg.dir_base = dir_base_r;

  // Front: accept and classify requests into a two-entry queue
  tlbw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .pop        (pop),
    .q_nonempty (q_nonempty),
    .q_head     (q_head)
  );

  // Back: lookup, walk, fill and hold the result until taken
  tlbw_back #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .sts        (sts),
    .out_chan   (out_chan)
  );

  // A lookup only starts with no walk open
  a_lookup_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sts.lookup |-> (sts.phase == tlbw_pkg::PH_IDLE))
    else $error("TLB lookup in flight while a walk is open");

  // A pending table read means the walk is still open
  a_read_walk_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.kind == tlbw_pkg::KIND_READ))
      |-> (sts.phase != tlbw_pkg::PH_IDLE))
    else $error("table read request with no walk open");

  // A final answer (address or fault) means no walk is left open
  a_final_walk_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.kind != tlbw_pkg::KIND_READ))
      |-> (sts.phase == tlbw_pkg::PH_IDLE))
    else $error("final result while a walk is still open");

  // Queue pops only when the back can take the item
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_nonempty && !sts.lookup))
    else $error("queue pop with no item or during a lookup");

endmodule

FILE: rtl/tlbw_front.sv
// Front end: accept requests, classify them and hold them in a short queue.
module tlbw_front (
  input  logic                clk,
  input  logic                rst_n,
  tlbw_in_if.sink             in_chan,
  input  logic                pop,
  output logic                q_nonempty,
  output tlbw_pkg::q_item_t   q_head
);

  tlbw_pkg::q_item_t               q_mem [tlbw_pkg::Q_DEPTH];
  logic [tlbw_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [tlbw_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [tlbw_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                            accept;
  logic                            push;
  logic                            do_pop;
  tlbw_pkg::q_item_t               item;

  assign in_chan.ready = (cnt_r != tlbw_pkg::Q_CNT_W'(tlbw_pkg::Q_DEPTH));
  assign accept        = in_chan.valid && in_chan.ready;
  assign q_nonempty    = (cnt_r != '0);
  assign do_pop        = pop && q_nonempty;
  assign q_head        = q_mem[rd_ptr_r];

  // Classify; undefined action codes are taken and dropped
  always_comb begin
    item.word = in_chan.linear_addr;
    item.op   = tlbw_pkg::OP_XLATE;
    push      = 1'b0;
    unique case (in_chan.action)
      tlbw_pkg::ACT_XLATE: begin
        item.op = tlbw_pkg::OP_XLATE;
        push    = accept;
      end
      tlbw_pkg::ACT_REPLY: begin
        item.op   = tlbw_pkg::OP_REPLY;
        item.word = in_chan.read_data;
        push      = accept;
      end
      tlbw_pkg::ACT_FLUSH: begin
        item.op = tlbw_pkg::OP_FLUSH;
        push    = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + tlbw_pkg::Q_CNT_W'(push) - tlbw_pkg::Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item;
    end
  end

endmodule

FILE: rtl/tlbw_back.sv
// Back end: TLB lookup, table walk sequencing, TLB fill and result register.
module tlbw_back #(
  parameter int unsigned TLB_ENTRIES = tlbw_pkg::TLB_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tlbw_pkg::cfg_t      cfg,
  input  logic                q_nonempty,
  input  tlbw_pkg::q_item_t   q_head,
  output logic                pop,
  output tlbw_pkg::status_t   sts,
  tlbw_out_if.source          out_chan
);

  localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned GS    = tlbw_pkg::GRP_SIZE;
  localparam int unsigned NG    = (TLB_ENTRIES + GS - 1) / GS;
  localparam int unsigned NP    = NG * GS;
  localparam int unsigned FW    = tlbw_pkg::FRAME_W;
  localparam int unsigned OW    = tlbw_pkg::OFFSET_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_GRP  = 3'd2;
  localparam logic [2:0] ST_SEL  = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  function automatic logic [tlbw_pkg::GRP_IDX_W-1:0] low_index(logic [GS-1:0] v);
    logic [tlbw_pkg::GRP_IDX_W-1:0] r;
    r = '0;
    for (int k = GS - 1; k >= 0; k--) begin
      if (v[k]) r = tlbw_pkg::GRP_IDX_W'(k);
    end
    return r;
  endfunction

  logic [2:0]                      st_r, st_nxt;
  logic [1:0]                      phase_r, phase_nxt;
  logic [31:0]                     pend_r, pend_nxt;
  logic [IDX_W-1:0]                victim_r, victim_nxt;
  logic [31:0]                     lk_r, lk_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_kind_r, out_kind_nxt;
  logic [31:0]                     out_addr_r, out_addr_nxt;
  logic                            out_free;
  logic                            fill_en;
  logic                            flush_en;

  logic [TLB_ENTRIES-1:0]          valid_r;
  logic [FW-1:0]                   tag_r [TLB_ENTRIES];
  logic [FW-1:0]                   frame_mem [TLB_ENTRIES];
  logic [FW-1:0]                   frame_q_r;

  logic [NP-1:0]                   match_c, free_c, match_r, free_r;
  logic [NG-1:0]                   ghit_r, gfree_r;
  logic [tlbw_pkg::GRP_IDX_W-1:0]  gidx_r [NG];
  logic [tlbw_pkg::GRP_IDX_W-1:0]  gfidx_r [NG];
  logic                            hit_c, hit_r;
  logic [IDX_W-1:0]                hit_idx_c, vict_c, vsel_r;

  assign out_free       = !out_valid_r || out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.kind  = out_kind_r;
  assign out_chan.address = out_addr_r;
  assign sts.lookup     = (st_r != ST_IDLE);
  assign sts.phase      = phase_r;

  // Tag compare across all entries
  always_comb begin
    match_c = '0;
    free_c  = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_c[i] = valid_r[i] && (tag_r[i] == lk_r[31:OW]);
      free_c[i]  = !valid_r[i];
    end
  end

  // Pick the lowest group with a hit / a free entry
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    vict_c    = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (ghit_r[g]) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(g * GS + int'(gidx_r[g]));
      end
      if (gfree_r[g]) begin
        vict_c = IDX_W'(g * GS + int'(gfidx_r[g]));
      end
    end
  end

  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    victim_nxt    = victim_r;
    lk_nxt        = lk_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    fill_en       = 1'b0;
    flush_en      = 1'b0;
    pop           = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_nonempty && out_free) begin
          pop = 1'b1;
          unique case (q_head.op)
            tlbw_pkg::OP_FLUSH: begin
              flush_en = 1'b1;
            end
            tlbw_pkg::OP_REPLY: begin
              if (phase_r == tlbw_pkg::PH_DIR) begin
                out_valid_nxt = 1'b1;
                if (!q_head.word[0]) begin
                  phase_nxt    = tlbw_pkg::PH_IDLE;
                  out_kind_nxt = tlbw_pkg::KIND_FAULT;
                  out_addr_nxt = pend_r;
                end else begin
                  phase_nxt    = tlbw_pkg::PH_TABLE;
                  out_kind_nxt = tlbw_pkg::KIND_READ;
                  out_addr_nxt = {q_head.word[31:OW], pend_r[21:OW], 2'b00};
                end
              end else if (phase_r == tlbw_pkg::PH_TABLE) begin
                out_valid_nxt = 1'b1;
                phase_nxt     = tlbw_pkg::PH_IDLE;
                if (!q_head.word[0]) begin
                  out_kind_nxt = tlbw_pkg::KIND_FAULT;
                  out_addr_nxt = pend_r;
                end else begin
                  fill_en      = 1'b1;
                  out_kind_nxt = tlbw_pkg::KIND_PHYS;
                  out_addr_nxt = {q_head.word[31:OW], pend_r[OW-1:0]};
                end
              end
            end
            tlbw_pkg::OP_XLATE: begin
              // Drop while a walk is open
              if (phase_r == tlbw_pkg::PH_IDLE) begin
                if (!cfg.xlate_on) begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = tlbw_pkg::KIND_PHYS;
                  out_addr_nxt  = q_head.word;
                end else begin
                  lk_nxt = q_head.word;
                  st_nxt = ST_CMP;
                end
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_CMP: st_nxt = ST_GRP;
      ST_GRP: st_nxt = ST_SEL;
      ST_SEL: st_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
          if (hit_r) begin
            out_kind_nxt = tlbw_pkg::KIND_PHYS;
            out_addr_nxt = {frame_q_r, lk_r[OW-1:0]};
          end else begin
            phase_nxt    = tlbw_pkg::PH_DIR;
            pend_nxt     = lk_r;
            victim_nxt   = vsel_r;
            out_kind_nxt = tlbw_pkg::KIND_READ;
            out_addr_nxt = {cfg.dir_base, lk_r[31:22], 2'b00};
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      phase_r     <= tlbw_pkg::PH_IDLE;
      pend_r      <= '0;
      victim_r    <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      victim_r    <= victim_nxt;
      out_valid_r <= out_valid_nxt;
      if (flush_en) begin
        valid_r <= '0;
      end else if (fill_en) begin
        valid_r[victim_r] <= 1'b1;
      end
    end
  end

  // Lookup pipeline and payload registers
  always_ff @(posedge clk) begin
    lk_r       <= lk_nxt;
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    match_r    <= match_c;
    free_r     <= free_c;
    for (int g = 0; g < NG; g++) begin
      ghit_r[g]  <= |match_r[g*GS +: GS];
      gidx_r[g]  <= low_index(match_r[g*GS +: GS]);
      gfree_r[g] <= |free_r[g*GS +: GS];
      gfidx_r[g] <= low_index(free_r[g*GS +: GS]);
    end
    hit_r  <= hit_c;
    vsel_r <= vict_c;
    if (fill_en) begin
      tag_r[victim_r] <= pend_r[31:OW];
    end
  end

  // Frame store: one write port for fills, one registered read for hits
  always_ff @(posedge clk) begin
    if (fill_en) begin
      frame_mem[victim_r] <= q_head.word[31:OW];
    end
    if (st_r == ST_SEL) begin
      frame_q_r <= frame_mem[hit_idx_c];
    end
  end

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the two-level page walk TLB block.
`timescale 1ns / 100ps

module tb_top;

  // The package names no code for the fourth action; the block ignores it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned SLOTS      = tlbw_pkg::TLB_ENTRIES_DEF;
  localparam int unsigned DRAIN_WAIT = 12;
  localparam int unsigned CYCLE_CAP  = 400000;  // far beyond the slowest correct run
  localparam int unsigned POOL_SIZE  = 96;      // more pages than TLB slots
  localparam int unsigned CHUNK      = 140;     // answers between register changes

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
  } mmu_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tlbw_in_if  in_chan ();
  tlbw_out_if out_chan ();

  tlb_two_level_page_walk_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the MMU: registers, TLB contents and the page walk in progress.
  logic        xlate_on_m;
  logic [19:0] dir_base_m;
  logic        slot_valid [SLOTS];
  logic [19:0] slot_tag   [SLOTS];
  logic [19:0] slot_frame [SLOTS];
  logic [1:0]  walk_ph;
  logic [31:0] walk_lin;
  int unsigned walk_victim;

  // Answers the MMU owes, oldest first.
  mmu_answer_t answers_q [$];

  // Pages reused by the random traffic so that lookups hit and slots wrap.
  logic [19:0] page_pool [POOL_SIZE];

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 51;

  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned n_requests   = 0;
  int unsigned n_results    = 0;
  int unsigned n_checked    = 0;
  int unsigned n_pass       = 0;
  int unsigned n_hits       = 0;
  int unsigned n_walk_reads = 0;
  int unsigned n_fills      = 0;
  int unsigned n_faults     = 0;
  int unsigned n_flushes    = 0;

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  function automatic void queue_answer(logic [1:0] kind, logic [31:0] address);
    mmu_answer_t ans;
    ans.kind    = kind;
    ans.address = address;
    answers_q.push_back(ans);
    n_results++;
  endfunction

  // Advance the shadow MMU by one accepted request and queue what it answers.
  function automatic void mmu_step(logic [1:0] action, logic [31:0] lin,
                                   logic [31:0] data);
    int hit;
    int i;
    hit = -1;
    if (action == tlbw_pkg::ACT_FLUSH) begin
      // Clear valid bits only; a walk in flight keeps its victim slot.
      for (i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      n_flushes++;
    end else if (action == tlbw_pkg::ACT_XLATE && walk_ph == tlbw_pkg::PH_IDLE) begin
      if (!xlate_on_m) begin
        queue_answer(tlbw_pkg::KIND_PHYS, lin);
        n_pass++;
      end else begin
        // Lowest-numbered matching slot wins.
        for (i = SLOTS - 1; i >= 0; i--)
          if (slot_valid[i] && slot_tag[i] == lin[31:12]) hit = i;
        if (hit >= 0) begin
          queue_answer(tlbw_pkg::KIND_PHYS, {slot_frame[hit], lin[11:0]});
          n_hits++;
        end else begin
          // Pick the lowest invalid slot now, or slot 0 if the TLB is full.
          walk_lin    = lin;
          walk_victim = 0;
          for (i = SLOTS - 1; i >= 0; i--)
            if (!slot_valid[i]) walk_victim = i;
          walk_ph = tlbw_pkg::PH_DIR;
          queue_answer(tlbw_pkg::KIND_READ,
                       {dir_base_m, 12'h000} + {20'h0, lin[31:22], 2'b00});
          n_walk_reads++;
        end
      end
    end else if (action == tlbw_pkg::ACT_REPLY && walk_ph == tlbw_pkg::PH_DIR) begin
      if (!data[0]) begin
        walk_ph = tlbw_pkg::PH_IDLE;
        queue_answer(tlbw_pkg::KIND_FAULT, walk_lin);
        n_faults++;
      end else begin
        walk_ph = tlbw_pkg::PH_TABLE;
        queue_answer(tlbw_pkg::KIND_READ,
                     {data[31:12], 12'h000} + {20'h0, walk_lin[21:12], 2'b00});
        n_walk_reads++;
      end
    end else if (action == tlbw_pkg::ACT_REPLY && walk_ph == tlbw_pkg::PH_TABLE) begin
      walk_ph = tlbw_pkg::PH_IDLE;
      if (!data[0]) begin
        queue_answer(tlbw_pkg::KIND_FAULT, walk_lin);
        n_faults++;
      end else begin
        slot_valid[walk_victim] = 1'b1;
        slot_tag[walk_victim]   = walk_lin[31:12];
        slot_frame[walk_victim] = data[31:12];
        queue_answer(tlbw_pkg::KIND_PHYS, {data[31:12], walk_lin[11:0]});
        n_fills++;
      end
    end
    // Anything else (translate while walking, reply while idle, unused action)
    // is dropped without an answer.
  endfunction

  // Offer one request, hold it until the block takes it, then predict.
  task automatic send_request(logic [1:0] action, logic [31:0] lin, logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.action      <= action;
    in_chan.linear_addr <= lin;
    in_chan.read_data   <= data;
    do @(posedge clk); while (!in_chan.ready);
    n_requests++;
    mmu_step(action, lin, data);
  endtask

  // Translate one address and answer the walk reads it causes, if any.
  task automatic run_walk(logic [31:0] lin, logic [31:0] dir_word, logic [31:0] tbl_word);
    send_request(tlbw_pkg::ACT_XLATE, lin, $urandom);
    if (walk_ph == tlbw_pkg::PH_DIR) send_request(tlbw_pkg::ACT_REPLY, $urandom, dir_word);
    if (walk_ph == tlbw_pkg::PH_TABLE) send_request(tlbw_pkg::ACT_REPLY, $urandom, tbl_word);
  endtask

  // Bring the block to rest: end any walk with a not-present entry, drop
  // valid, wait for every owed answer and then for the pipeline to empty.
  task automatic settle_block();
    if (walk_ph != tlbw_pkg::PH_IDLE)
      send_request(tlbw_pkg::ACT_REPLY, $urandom, 32'h0000_0000);
    in_chan.valid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_register(logic reg_idx, logic [31:0] value);
    logic [31:0] want;
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == tlbw_pkg::REG_XLATE_ON) begin
      xlate_on_m = value[0];
      want       = {31'h0, value[0]};
    end else begin
      dir_base_m = value[19:0];
      want       = {12'h0, value[19:0]};
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d reads %08h, wrote %08h", reg_idx, prdata,
                                want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] random_lin();
    if ($urandom_range(99) < 75)
      return {page_pool[$urandom_range(POOL_SIZE - 1)], 12'($urandom)};
    return $urandom;
  endfunction

  // Table word with random content, present most of the time.
  function automatic logic [31:0] random_entry();
    logic [31:0] word;
    word    = $urandom;
    word[0] = ($urandom_range(99) < 92);
    return word;
  endfunction

  // Check each answer against the oldest one owed; drive ready at random.
  always @(posedge clk) begin : check_answers
    mmu_answer_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_checked++;
      if (answers_q.size() == 0) begin
        report_mismatch($sformatf("unexpected answer kind %0d address %08h",
                                  out_chan.kind, out_chan.address));
      end else begin
        want = answers_q.pop_front();
        if (out_chan.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_chan.kind, want.kind));
        if (out_chan.address !== want.address)
          report_mismatch($sformatf("address %08h, expected %08h", out_chan.address,
                                    want.address));
      end
    end
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d answers still owed", cycle_count,
               answers_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Translation off: every translate comes straight back; other actions drop.
  task automatic test_pass_through();
    send_request(tlbw_pkg::ACT_XLATE, 32'h0000_0000, 32'h0000_0000);
    send_request(tlbw_pkg::ACT_XLATE, 32'hffff_ffff, 32'hffff_ffff);
    send_request(tlbw_pkg::ACT_REPLY, 32'h1357_9bdf, 32'hffff_ffff);
    send_request(tlbw_pkg::ACT_FLUSH, 32'hffff_ffff, 32'h0000_0000);
    send_request(ACT_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_request(tlbw_pkg::ACT_XLATE, 32'ha5a5_5a5a, 32'h5a5a_a5a5);
    settle_block();
  endtask

  // Paging on: fills, hits, faults at each level, and stray requests mid-walk.
  task automatic test_walk_cases();
    write_register(tlbw_pkg::REG_DIR_BASE, 32'h000f_ffff);
    write_register(tlbw_pkg::REG_XLATE_ON, 32'h0000_0001);
    run_walk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(tlbw_pkg::ACT_XLATE, 32'hffff_f000, 32'h0000_0000);
    run_walk(32'h0000_0000, 32'h0000_0001, 32'h0000_0001);
    write_register(tlbw_pkg::REG_DIR_BASE, 32'h0000_0000);
    // Directory entry not present.
    run_walk(32'h0040_0123, 32'hffff_fffe, 32'hffff_ffff);
    // Table entry not present.
    run_walk(32'h0080_0abc, 32'hffff_ffff, 32'hffff_fffe);
    // Translate, unused action and flush arriving during a walk.
    send_request(tlbw_pkg::ACT_XLATE, 32'h1234_5678, 32'h0000_0000);
    send_request(tlbw_pkg::ACT_XLATE, 32'h9abc_def0, 32'h0000_0000);
    send_request(ACT_UNUSED, 32'h0000_0000, 32'h0000_0001);
    send_request(tlbw_pkg::ACT_FLUSH, 32'h0000_0000, 32'h0000_0000);
    send_request(tlbw_pkg::ACT_REPLY, 32'h0000_0000, 32'h0000_3001);
    send_request(tlbw_pkg::ACT_XLATE, 32'h0000_0000, 32'h0000_0000);
    send_request(tlbw_pkg::ACT_REPLY, 32'h0000_0000, 32'h0003_5001);
    // The fill lands in the slot picked before the flush; a hit on it, then a fresh miss.
    send_request(tlbw_pkg::ACT_XLATE, 32'h1234_5fff, 32'h0000_0000);
    run_walk(32'hffff_ffff, 32'h8000_0001, 32'h7fff_f001);
    settle_block();
  endtask

  // Mostly complete walks over a reused page set, with noise and rare flushes.
  task automatic test_random_traffic(int unsigned target, int unsigned tx_pct,
                                     int unsigned rx_pct);
    int unsigned start;
    int unsigned chunk_end;
    int unsigned pick;
    start         = n_results;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    while (n_results - start < target) begin
      // Change settings at rest; paging is on for most chunks.
      write_register(tlbw_pkg::REG_XLATE_ON, {31'h0, 1'($urandom_range(99) < 85)});
      pick = $urandom_range(2);
      write_register(tlbw_pkg::REG_DIR_BASE, (pick == 0) ? 32'h0000_0000 :
                                   (pick == 1) ? 32'h000f_ffff : {12'h0, 20'($urandom)});
      chunk_end = n_results + CHUNK;
      while (n_results < chunk_end && n_results - start < target) begin
        pick = $urandom_range(199);
        if (pick < 170)
          run_walk(random_lin(), random_entry(), random_entry());
        else if (pick < 171)
          send_request(tlbw_pkg::ACT_FLUSH, $urandom, $urandom);
        else
          send_request(2'($urandom_range(3)), random_lin(), random_entry());
      end
    end
    settle_block();
  endtask

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.action      = tlbw_pkg::ACT_XLATE;
    in_chan.linear_addr = 32'h0;
    in_chan.read_data   = 32'h0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = 3'h0;
    pwdata              = 32'h0;

    // Shadow state matches the block after reset.
    xlate_on_m  = 1'b0;
    dir_base_m  = 20'h0;
    walk_ph     = tlbw_pkg::PH_IDLE;
    walk_lin    = 32'h0;
    walk_victim = 0;
    for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = 20'($urandom);
    page_pool[0] = 20'h00000;
    page_pool[1] = 20'hfffff;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_pass_through();
    test_walk_cases();
    test_random_traffic(430, 6, 51);
    test_random_traffic(430, 51, 6);
    test_random_traffic(430, 0, 0);
    settle_block();

    $display("Sent %0d requests (%0d flushes); checked %0d answers, %0d mismatches",
             n_requests, n_flushes, n_checked, errors);
    $display("Answers: %0d pass-through, %0d TLB hits, %0d walk reads, %0d fills, %0d faults",
             n_pass, n_hits, n_walk_reads, n_fills, n_faults);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tlbw_pkg.sv
rtl/tlbw_if.sv
rtl/tlbw_front.sv
rtl/tlbw_back.sv
rtl/tlb_two_level_page_walk_top.sv
sim/tb_top.sv
